// File: src/sswp_pkg.sv
// sswp_pkg: shared types and constants of the square-sum window pyramid
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sswp_pkg;

  localparam int LEVEL_W    = 3;   // result level field
  localparam int POS_W      = 10;  // result row and column fields
  localparam int SUM_W      = 30;  // result square sum field
  localparam int PIXEL_W    = 8;   // input pixel field
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int LVLCNT_W   = 4;

  localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] FRAME_COLS_RST  = 11'd1024;
  localparam logic [LVLCNT_W-1:0]   LEVEL_COUNT_RST = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS  = 2'd0,
    CFG_FRAME_COLS  = 2'd1,
    CFG_LEVEL_COUNT = 2'd2
  } cfg_reg_t;

  // control of one level pass, sequencer to accumulator
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic               has_up;    // row r - 2^k lies in the frame
    logic               row_zero;  // first row, column sum starts fresh
    logic               col_zero;  // first column, row sum starts fresh
    logic               has_left;  // column c - 2^k lies in the frame
    logic               emit;      // window fits and level is enabled
    logic               last;      // final result of this pixel
  } issue_ctl_t;

endpackage
`default_nettype wire

// File: src/square_sum_window_pyramid.sv
// square_sum_window_pyramid: top level, sequencer, accumulator, three rams
// depends on sswp_pkg, sswp_ram, sswp_seq, sswp_acc
//
// Streams pixels in raster order and, for each level k below level_count, returns the
// sum of squared pixels over the 2^k x 2^k window ending at the current pixel, as soon
// as that window fits inside the frame; results come in ascending level order and
// tlast marks the final one of a pixel. Each pixel is issued once for each of the
// MAX_LEVELS levels (8 by default), as the column-sum memory takes a single
// read-modify-write per level; a new pixel is taken in the cycle its predecessor's
// last level issues, so pixels follow each other without gaps. With a single level
// a bubble between pixels keeps the column-sum write ahead of the next read, and
// pixels are not taken back to back. Any stall on the result side
// freezes the whole pipeline. No clearing pass is needed after reset: first-row and
// first-column flags replace the stored sums, and the line store is only read at rows
// already written in the current frame. A write to any configuration register
// restarts the frame at row 0, column 0; write registers only while idle.
`timescale 1ns / 1ps
`default_nettype none
module square_sum_window_pyramid #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_LEVELS = 8,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel words
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] pixel
  // result words
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [55:0]                     out_tdata,  // [9:0] top_row, [19:10] left_col,
                                                           // [49:20] square_sum, rest zero
  output logic      [2:0]                      out_tuser,  // [2:0] level
  output logic                                 out_tlast,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [sswp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sswp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sswp_pkg::*;

  localparam int WIN   = 1 << (MAX_LEVELS - 1);
  localparam int SQ_W  = 2 * PIXEL_BITS;
  localparam int CS_W  = SQ_W + MAX_LEVELS - 1;
  localparam int RS_W  = SQ_W + 2 * (MAX_LEVELS - 1);
  localparam int LS_D  = WIN * MAX_COLS;
  localparam int CS_D  = MAX_LEVELS * MAX_COLS;
  localparam int LS_AW = (LS_D > 1) ? $clog2(LS_D) : 1;
  localparam int CS_AW = (CS_D > 1) ? $clog2(CS_D) : 1;

  // pipeline advances whenever the output register can take a word
  logic adv;

  issue_ctl_t        ctl;
  logic [SQ_W-1:0]   sq;
  logic [POS_W-1:0]  top_row, left_col;
  logic              ls_we;
  logic [LS_AW-1:0]  ls_waddr, ls_raddr;
  logic [CS_AW-1:0]  csa_raddr, csb_raddr;
  logic [SQ_W-1:0]   ls_q;
  logic [CS_W-1:0]   csa_q, csb_q;
  logic              cs_we;
  logic [CS_AW-1:0]  cs_waddr;
  logic [CS_W-1:0]   cs_wdata;

  logic              res_valid, res_last;
  logic [LEVEL_W-1:0] res_level;
  logic [POS_W-1:0]  res_top, res_left;
  logic [SUM_W-1:0]  res_sum;

  // output register
  logic              out_valid_r, out_last_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [POS_W-1:0]  out_top_r, out_left_r;
  logic [SUM_W-1:0]  out_sum_r;

  assign adv = !out_valid_r || out_tready;

  sswp_seq #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_LEVELS(MAX_LEVELS),
    .PIXEL_BITS(PIXEL_BITS), .LS_AW(LS_AW), .CS_AW(CS_AW)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_pixel(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ctl(ctl), .sq(sq), .top_row(top_row), .left_col(left_col),
    .ls_we(ls_we), .ls_waddr(ls_waddr), .ls_raddr(ls_raddr),
    .csa_raddr(csa_raddr), .csb_raddr(csb_raddr)
  );

  // squares of the last 2^(MAX_LEVELS-1) rows; read-first keeps the oldest row
  // readable in the cycle it is overwritten
  sswp_ram #(.WIDTH(SQ_W), .DEPTH(LS_D), .AW(LS_AW)) u_line_ram (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(sq),
    .re(adv), .raddr(ls_raddr), .rdata(ls_q)
  );

  // column sums, duplicated for a second read port (own column, column - 2^k)
  sswp_ram #(.WIDTH(CS_W), .DEPTH(CS_D), .AW(CS_AW)) u_col_ram_a (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .re(adv), .raddr(csa_raddr), .rdata(csa_q)
  );

  sswp_ram #(.WIDTH(CS_W), .DEPTH(CS_D), .AW(CS_AW)) u_col_ram_b (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .re(adv), .raddr(csb_raddr), .rdata(csb_q)
  );

  sswp_acc #(
    .MAX_LEVELS(MAX_LEVELS), .SQ_W(SQ_W), .CS_W(CS_W), .RS_W(RS_W), .CS_AW(CS_AW)
  ) u_acc (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .ctl_i(ctl), .sq_i(sq), .top_row_i(top_row), .left_col_i(left_col),
    .cs_addr_i(csa_raddr), .ls_q(ls_q), .csa_q(csa_q), .csb_q(csb_q),
    .cs_we(cs_we), .cs_waddr(cs_waddr), .cs_wdata(cs_wdata),
    .res_valid(res_valid), .res_level(res_level), .res_top_row(res_top),
    .res_left_col(res_left), .res_sum(res_sum), .res_last(res_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r <= res_level;
      out_top_r   <= res_top;
      out_left_r  <= res_left;
      out_sum_r   <= res_sum;
      out_last_r  <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_sum_r, out_left_r, out_top_r};
  assign out_tuser  = out_level_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// File: src/sswp_ram.sv
// sswp_ram: generic single-write, single-read ram, registered read-first output
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sswp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: src/sswp_seq.sv
// sswp_seq: frame position, config registers and per-level address issue
// depends on sswp_pkg
`timescale 1ns / 1ps
`default_nettype none
module sswp_seq #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_LEVELS = 8,
  parameter int PIXEL_BITS = 8,
  parameter int LS_AW      = 17,
  parameter int CS_AW      = 13
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [sswp_pkg::PIXEL_W-1:0]        in_pixel,
  input  wire logic                                cfg_we,
  input  wire logic [sswp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sswp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output sswp_pkg::issue_ctl_t                     ctl,
  output logic      [2*PIXEL_BITS-1:0]             sq,
  output logic      [sswp_pkg::POS_W-1:0]          top_row,
  output logic      [sswp_pkg::POS_W-1:0]          left_col,
  output logic                                     ls_we,
  output logic      [LS_AW-1:0]                    ls_waddr,
  output logic      [LS_AW-1:0]                    ls_raddr,
  output logic      [CS_AW-1:0]                    csa_raddr,
  output logic      [CS_AW-1:0]                    csb_raddr
);
  import sswp_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int WIN   = 1 << (MAX_LEVELS - 1);
  localparam int SQ_W  = 2 * PIXEL_BITS;
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(MAX_LEVELS - 1);
  // with one level a pixel needs a bubble so its column-sum write lands first
  localparam bit OVERLAP_OK = (MAX_LEVELS > 1);

  logic [CFG_DATA_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [LVLCNT_W-1:0]   lvls_cfg_r;
  logic [ROW_W-1:0]      cur_row_r, row_r;
  logic [COL_W-1:0]      cur_col_r, col_r;
  logic [LVL_W-1:0]      lvl_r;
  logic                  busy_r;
  logic [SQ_W-1:0]       sq_r;
  logic [PIXEL_BITS-1:0] px;
  logic                  accept, lvl_done;

  int unsigned rows_eff, cols_eff, lvls_eff;
  int unsigned r0, c0, nr, nc;
  int unsigned r, c, k, side, side2;
  logic        fit, fit_next;

  always_comb begin
    rows_eff = (rows_cfg_r == '0) ? 1 :
               ((32'(rows_cfg_r) > MAX_ROWS) ? MAX_ROWS : 32'(rows_cfg_r));
    cols_eff = (cols_cfg_r == '0) ? 1 :
               ((32'(cols_cfg_r) > MAX_COLS) ? MAX_COLS : 32'(cols_cfg_r));
    lvls_eff = (lvls_cfg_r == '0) ? 1 :
               ((32'(lvls_cfg_r) > MAX_LEVELS) ? MAX_LEVELS : 32'(lvls_cfg_r));
    // position of the arriving pixel, restart when past the frame
    if (32'(cur_row_r) >= rows_eff || 32'(cur_col_r) >= cols_eff) begin
      r0 = 0;
      c0 = 0;
    end else begin
      r0 = 32'(cur_row_r);
      c0 = 32'(cur_col_r);
    end
    nc = c0 + 1;
    nr = r0;
    if (nc >= cols_eff) begin
      nc = 0;
      nr = (r0 + 1 >= rows_eff) ? 0 : r0 + 1;
    end
  end

  assign lvl_done = (lvl_r == LVL_LAST);
  assign in_ready = adv && (!busy_r || (lvl_done && OVERLAP_OK));
  assign accept   = in_valid && in_ready;
  assign px       = PIXEL_BITS'(in_pixel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= FRAME_ROWS_RST;
      cols_cfg_r <= FRAME_COLS_RST;
      lvls_cfg_r <= LEVEL_COUNT_RST;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      busy_r     <= 1'b0;
      lvl_r      <= '0;
    end else begin
      if (accept) begin
        busy_r    <= 1'b1;
        lvl_r     <= '0;
        cur_row_r <= ROW_W'(nr);
        cur_col_r <= COL_W'(nc);
      end else if (adv && busy_r) begin
        if (lvl_done) begin
          busy_r <= 1'b0;
        end else begin
          lvl_r <= lvl_r + 1'b1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_ROWS: begin
            rows_cfg_r <= cfg_data;
            cur_row_r  <= '0;
            cur_col_r  <= '0;
          end
          CFG_FRAME_COLS: begin
            cols_cfg_r <= cfg_data;
            cur_row_r  <= '0;
            cur_col_r  <= '0;
          end
          CFG_LEVEL_COUNT: begin
            lvls_cfg_r <= LVLCNT_W'(cfg_data);
            cur_row_r  <= '0;
            cur_col_r  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= ROW_W'(r0);
      col_r <= COL_W'(c0);
      sq_r  <= SQ_W'(px) * SQ_W'(px);
    end
  end

  // per-level issue
  always_comb begin
    r        = 32'(row_r);
    c        = 32'(col_r);
    k        = 32'(lvl_r);
    side     = 32'd1 << k;
    side2    = side << 1;
    fit      = (r + 1 >= side) && (c + 1 >= side);
    fit_next = (k + 1 < lvls_eff) && (r + 1 >= side2) && (c + 1 >= side2);

    ctl.valid    = busy_r;
    ctl.level    = LEVEL_W'(lvl_r);
    ctl.has_up   = (r >= side);
    ctl.row_zero = (r == 0);
    ctl.col_zero = (c == 0);
    ctl.has_left = (c >= side);
    ctl.emit     = fit && (k < lvls_eff);
    ctl.last     = fit && (k < lvls_eff) && !fit_next;

    top_row  = POS_W'(r + 1 - side);
    left_col = POS_W'(c + 1 - side);
    sq       = sq_r;

    ls_raddr  = LS_AW'((((r - side) & (WIN - 1)) * MAX_COLS) + c);
    ls_waddr  = LS_AW'(((r & (WIN - 1)) * MAX_COLS) + c);
    ls_we     = adv && busy_r && lvl_done;
    csa_raddr = CS_AW'(k * MAX_COLS + c);
    csb_raddr = (c >= side) ? CS_AW'(k * MAX_COLS + c - side) : CS_AW'(k * MAX_COLS + c);
  end

endmodule
`default_nettype wire

// File: src/sswp_acc.sv
// sswp_acc: column-sum update and per-level row window sums, two stages
// depends on sswp_pkg
`timescale 1ns / 1ps
`default_nettype none
module sswp_acc #(
  parameter int MAX_LEVELS = 8,
  parameter int SQ_W       = 16,
  parameter int CS_W       = 23,
  parameter int RS_W       = 30,
  parameter int CS_AW      = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire sswp_pkg::issue_ctl_t          ctl_i,
  input  wire logic [SQ_W-1:0]               sq_i,
  input  wire logic [sswp_pkg::POS_W-1:0]    top_row_i,
  input  wire logic [sswp_pkg::POS_W-1:0]    left_col_i,
  input  wire logic [CS_AW-1:0]              cs_addr_i,
  input  wire logic [SQ_W-1:0]               ls_q,
  input  wire logic [CS_W-1:0]               csa_q,
  input  wire logic [CS_W-1:0]               csb_q,
  output logic                               cs_we,
  output logic      [CS_AW-1:0]              cs_waddr,
  output logic      [CS_W-1:0]               cs_wdata,
  output logic                               res_valid,
  output logic      [sswp_pkg::LEVEL_W-1:0]  res_level,
  output logic      [sswp_pkg::POS_W-1:0]    res_top_row,
  output logic      [sswp_pkg::POS_W-1:0]    res_left_col,
  output logic      [sswp_pkg::SUM_W-1:0]    res_sum,
  output logic                               res_last
);
  import sswp_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  issue_ctl_t        s1_ctl_r, s2_ctl_r;
  logic [SQ_W-1:0]   s1_sq_r;
  logic [CS_AW-1:0]  s1_addr_r;
  logic [POS_W-1:0]  s1_top_r, s1_left_r, s2_top_r, s2_left_r;
  logic [CS_W-1:0]   s2_cs_r, s2_old_r;
  logic [RS_W-1:0]   rws_r [MAX_LEVELS];

  logic [SQ_W-1:0]   old_sq;
  logic [CS_W-1:0]   old_cs, new_cs, old_col;
  logic [RS_W-1:0]   base, rws_nxt;
  logic [LVL_W-1:0]  s2_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= ctl_i;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sq_r   <= sq_i;
      s1_addr_r <= cs_addr_i;
      s1_top_r  <= top_row_i;
      s1_left_r <= left_col_i;
      s2_cs_r   <= new_cs;
      s2_old_r  <= old_col;
      s2_top_r  <= s1_top_r;
      s2_left_r <= s1_left_r;
    end
  end

  // stage 1: column sum over the last 2^k rows
  always_comb begin
    old_sq   = s1_ctl_r.has_up ? ls_q : '0;
    old_cs   = s1_ctl_r.row_zero ? '0 : csa_q;
    new_cs   = old_cs + CS_W'(s1_sq_r) - CS_W'(old_sq);
    old_col  = s1_ctl_r.has_left ? csb_q : '0;
    cs_we    = adv && s1_ctl_r.valid;
    cs_waddr = s1_addr_r;
    cs_wdata = new_cs;
  end

  // stage 2: running window sum along the row
  always_comb begin
    s2_idx  = s2_ctl_r.level[LVL_W-1:0];
    base    = s2_ctl_r.col_zero ? '0 : rws_r[s2_idx];
    rws_nxt = base + RS_W'(s2_cs_r) - RS_W'(s2_old_r);
  end

  always_ff @(posedge clk) begin
    if (adv && s2_ctl_r.valid) begin
      rws_r[s2_idx] <= rws_nxt;
    end
  end

  assign res_valid    = s2_ctl_r.valid && s2_ctl_r.emit;
  assign res_level    = s2_ctl_r.level;
  assign res_top_row  = s2_top_r;
  assign res_left_col = s2_left_r;
  assign res_sum      = SUM_W'(rws_nxt);
  assign res_last     = s2_ctl_r.last;

endmodule
`default_nettype wire

// File: src/sswp_checker.sv
// sswp_checker: port-level checks of square_sum_window_pyramid, bound to the top
// depends on square_sum_window_pyramid ports only
`timescale 1ns / 1ps
`default_nettype none
module sswp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast)))
    else $error("result word changed while stalled");

  // a stalled result side freezes the pipeline, so no pixel is taken
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("pixel taken while result stalled");

  // a taken pixel keeps the sequencer busy, so no pixel is taken in the next cycle
  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("pixel taken in consecutive cycles");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind square_sum_window_pyramid sswp_checker u_sswp_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire

// File: tb/square_sum_window_pyramid_tb.sv
// square_sum_window_pyramid_tb: self-checking bench for the square-sum window pyramid
// depends on sswp_pkg and square_sum_window_pyramid; predicts every result word and
// compares it field by field while both stream sides idle and stall at random
`timescale 1ns / 1ps
`default_nettype none
module square_sum_window_pyramid_tb;
  import sswp_pkg::*;

  localparam int ROWS_MAX   = 1024;
  localparam int COLS_MAX   = 1024;
  localparam int LEVELS_MAX = 8;
  localparam int LINE_DEPTH = 1 << (LEVELS_MAX - 1);
  // slack after the last result before a register write or the end of the run
  localparam int SETTLE_CYCLES = 4 * LEVELS_MAX + 8;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   top_row;
    logic [POS_W-1:0]   left_col;
    logic [SUM_W-1:0]   square_sum;
    logic               last;
  } window_sum_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [55:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  square_sum_window_pyramid i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block: registers, position and running sums
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  logic [LVLCNT_W-1:0]   levels_reg;
  int unsigned pos_row;
  int unsigned pos_col;
  int unsigned line_squares [0:LINE_DEPTH*COLS_MAX-1];
  int unsigned column_sq_sums [0:LEVELS_MAX*COLS_MAX-1];
  int unsigned row_sq_sums [0:LEVELS_MAX-1];

  window_sum_t pending_sums[$];
  int  error_count;
  bit  steady;          // no random idling on either side while set
  int  sink_hold;       // cycles the result side still has to hold off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // runs one pixel through the shadow and queues the window sums it yields
  task automatic predict_pixel(input logic [7:0] px);
    int unsigned rows, cols, lvls, r, c, sq, side, old_sq, old_col, base;
    window_sum_t found[$];
    window_sum_t w;
    rows = clamp_reg(32'(rows_reg), ROWS_MAX);
    cols = clamp_reg(32'(cols_reg), COLS_MAX);
    lvls = clamp_reg(32'(levels_reg), LEVELS_MAX);
    if (pos_row >= rows || pos_col >= cols) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    // new frame clears the column sums, new row the running row sums
    if (r == 0 && c == 0) begin
      foreach (column_sq_sums[i]) column_sq_sums[i] = 0;
    end
    if (c == 0) begin
      foreach (row_sq_sums[i]) row_sq_sums[i] = 0;
    end
    sq = 32'(px) * 32'(px);
    for (int k = 0; k < LEVELS_MAX; k++) begin
      side = 1 << k;
      base = k * COLS_MAX;
      old_sq = 0;
      old_col = 0;
      if (r >= side) old_sq = line_squares[((r - side) % LINE_DEPTH) * COLS_MAX + c];
      column_sq_sums[base + c] = column_sq_sums[base + c] + sq - old_sq;
      if (c >= side) old_col = column_sq_sums[base + c - side];
      row_sq_sums[k] = row_sq_sums[k] + column_sq_sums[base + c] - old_col;
    end
    line_squares[(r % LINE_DEPTH) * COLS_MAX + c] = sq;
    for (int k = 0; k < lvls; k++) begin
      side = 1 << k;
      if (r + 1 >= side && c + 1 >= side) begin
        w.level      = LEVEL_W'(k);
        w.top_row    = POS_W'(r + 1 - side);
        w.left_col   = POS_W'(c + 1 - side);
        w.square_sum = SUM_W'(row_sq_sums[k]);
        w.last       = 1'b0;
        found.push_back(w);
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_sums.push_back(found[i]);
    pos_col = c + 1;
    if (pos_col >= cols) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= rows) pos_row = 0;
    end
  endtask

  // offers one pixel word, with a random gap ahead of it unless steady
  task automatic send_pixel(input logic [7:0] px);
    while (!steady && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    predict_pixel(px);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_ROWS:  rows_reg = val;
      CFG_FRAME_COLS:  cols_reg = val;
      CFG_LEVEL_COUNT: levels_reg = val[LVLCNT_W-1:0];
      default: ;
    endcase
    // a write to a real register restarts the frame
    if (idx != CFG_NO_REG) begin
      pos_row = 0;
      pos_col = 0;
    end
  endtask

  task automatic set_frame(input int r, input int c, input int l);
    write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(r));
    write_reg(CFG_FRAME_COLS, CFG_DATA_W'(c));
    write_reg(CFG_LEVEL_COUNT, CFG_DATA_W'(l));
  endtask

  // result side: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
    end
  end

  // compare each accepted result word with the oldest predicted window sum
  always @(posedge clk) begin
    window_sum_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.level      = out_tuser;
      got.top_row    = out_tdata[9:0];
      got.left_col   = out_tdata[19:10];
      got.square_sum = out_tdata[49:20];
      got.last       = out_tlast;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        error_count++;
      end else begin
        want = pending_sums.pop_front();
        if (got !== want || out_tdata[55:50] !== 6'd0) begin
          $display("%0t: mismatch expected %p actual %p (tdata %h)", $time, want, got,
                   out_tdata);
          error_count++;
        end
      end
    end
  end

  // reset defaults: single row only gives level zero, pixel extremes
  task automatic test_reset_frame();
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'hAA);
    send_pixel(8'h55);
  endtask

  // small frame that wraps into a second frame, column sums must restart
  task automatic test_frame_wrap();
    set_frame(3, 3, 2);
    for (int i = 0; i < 12; i++) send_pixel(i[0] ? 8'd0 : 8'd255);
  endtask

  // out-of-range values clamp; unknown index leaves the position alone
  task automatic test_reg_clamp();
    set_frame(0, 0, 0);
    send_pixel(8'd255);
    send_pixel(8'd7);
    set_frame(2047, 2047, 15);
    send_pixel(8'd255);
    send_pixel(8'd1);
    set_frame(4, 4, 8);
    send_pixel(8'd9);
    send_pixel(8'd200);
    write_reg(CFG_NO_REG, 11'h7FF);
    for (int i = 0; i < 6; i++) send_pixel(8'd255);
  endtask

  // random frames, mostly small, with an 8x8 frame reaching level three
  task automatic test_random_frames();
    set_frame(8, 8, 8);
    steady = 1'b1;
    for (int i = 0; i < 64; i++) send_pixel(8'($urandom_range(255)));
    steady = 1'b0;
    for (int p = 0; p < 2; p++) begin
      set_frame($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 15));
      for (int i = 0; i < 4; i++) send_pixel(8'($urandom_range(255)));
    end
  endtask

  // long hold-off on the result side while pixels keep coming
  task automatic test_backpressure();
    set_frame(4, 5, 3);
    steady = 1'b1;
    sink_hold = 300;
    for (int i = 0; i < 12; i++) send_pixel(8'($urandom_range(255)));
    steady = 1'b0;
  endtask

  initial begin
    error_count = 0;
    steady = 1'b0;
    sink_hold = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_ROWS;
    cfg_data = '0;
    rows_reg = FRAME_ROWS_RST;
    cols_reg = FRAME_COLS_RST;
    levels_reg = LEVEL_COUNT_RST;
    pos_row = 0;
    pos_col = 0;
    foreach (line_squares[i]) line_squares[i] = 0;
    foreach (column_sq_sums[i]) column_sq_sums[i] = 0;
    foreach (row_sq_sums[i]) row_sq_sums[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_frame();
    test_frame_wrap();
    test_reg_clamp();
    test_random_frames();
    test_backpressure();

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/sswp_pkg.sv
src/sswp_ram.sv
src/sswp_seq.sv
src/sswp_acc.sv
src/square_sum_window_pyramid.sv
src/sswp_checker.sv
tb/square_sum_window_pyramid_tb.sv
